// File: sv/line_index_offset_to_line_col_defines.svh
// ----------------------------------------------------------------------------
// Line index locator assertion macros
// Shared concurrent-check wrappers, clocked and gated by the block reset.
// ----------------------------------------------------------------------------
`ifndef LINE_INDEX_OFFSET_TO_LINE_COL_DEFINES_SVH
`define LINE_INDEX_OFFSET_TO_LINE_COL_DEFINES_SVH

// Same-cycle implication.
`define LIOC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LIOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lioc_pkg.sv
// ----------------------------------------------------------------------------
// Line index locator package
// Request codes and fixed field widths of the stream ports.
// ----------------------------------------------------------------------------
package lioc_pkg;

  localparam int OPCODE_W    = 2;
  localparam int TEXT_BYTE_W = 8;
  localparam int QUERY_W     = 16;
  localparam int LINE_W      = 13;
  localparam int COL_W       = 17;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 32;

  localparam logic [TEXT_BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e;

endpackage

// File: sv/line_index_offset_to_line_col.sv
// ----------------------------------------------------------------------------
// Line index and offset-to-line/column locator
// Clear and append requests are applied on acceptance; a query runs P probes
// of the line-start table (at most 13 for 4096 lines) before its result,
// one probe per cycle through the single read port of the table memory.
// One request at a time; a finished result waits in the output register.
// Reset: one line starting at offset 0, empty text, overflow clear.
// ----------------------------------------------------------------------------
`include "line_index_offset_to_line_col_defines.svh"

module line_index_offset_to_line_col #(
  parameter int MAX_LINES   = 4096,
  parameter int OFFSET_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // text_byte [7:0], query_offset [23:8]
  input  logic [lioc_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // opcode [1:0]
  input  logic [lioc_pkg::OPCODE_W-1:0]    s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // line_number [12:0], column_number [29:13], overflow_flag [30], zero [31]
  output logic [lioc_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam int IDX_W  = $clog2(MAX_LINES);
  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  localparam int OFF_W  = OFFSET_BITS;
  localparam int CMP_W  = (OFF_W > lioc_pkg::QUERY_W) ? OFF_W : lioc_pkg::QUERY_W;
  localparam int COLX_W = (OFF_W + 1 > lioc_pkg::COL_W) ? OFF_W + 1 : lioc_pkg::COL_W;
  localparam int LNX_W  = (CNT_W > lioc_pkg::LINE_W) ? CNT_W : lioc_pkg::LINE_W;
  localparam int PAD_W  = lioc_pkg::M_TDATA_W - lioc_pkg::LINE_W - lioc_pkg::COL_W - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [OFF_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             m_valid_q, m_valid_d;
  logic [lioc_pkg::M_TDATA_W-1:0] m_data_q, m_data_d;

  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic             mid_zero_q, mid_zero_d;
  logic [OFF_W-1:0] off_q, off_d, best_q, best_d;

  logic [OFF_W-1:0] mem [MAX_LINES];
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [OFF_W-1:0] wr_data, rd_data_q;

  lioc_pkg::opcode_e             opcode;
  logic [lioc_pkg::TEXT_BYTE_W-1:0] text_byte;
  logic [CMP_W-1:0]              query_ext, len_ext;
  logic                          in_fire;
  logic [OFF_W-1:0]              probe_start;
  logic [CNT_W-1:0]              lo_n, hi_n, mid_n;
  logic [COLX_W-1:0]             colx;
  logic [LNX_W-1:0]              lnx;

  assign opcode    = lioc_pkg::opcode_e'(s_axis_tuser_i);
  assign text_byte = s_axis_tdata_i[lioc_pkg::TEXT_BYTE_W-1:0];
  assign query_ext = CMP_W'(s_axis_tdata_i[lioc_pkg::TEXT_BYTE_W +: lioc_pkg::QUERY_W]);
  assign len_ext   = CMP_W'(len_q);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign probe_start = mid_zero_q ? '0 : rd_data_q;
  assign colx = COLX_W'(off_q) - COLX_W'(best_q) + COLX_W'(1);
  assign lnx  = LNX_W'(lo_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    mid_zero_d = mid_zero_q;
    off_d      = off_q;
    best_d     = best_q;
    rd_en      = 1'b0;
    rd_addr    = mid_q[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = count_q[IDX_W-1:0];
    wr_data    = len_q + OFF_W'(1);
    lo_n       = lo_q;
    hi_n       = hi_q;
    mid_n      = mid_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (opcode)
            lioc_pkg::OP_CLEAR: begin
              count_d = CNT_W'(1);
              len_d   = '0;
              ovf_d   = 1'b0;
            end
            lioc_pkg::OP_APPEND: begin
              if (&len_q) begin
                ovf_d = 1'b1;
              end else begin
                len_d = len_q + OFF_W'(1);
                if (text_byte == lioc_pkg::NEWLINE_BYTE) begin
                  if (count_q < CNT_W'(MAX_LINES)) begin
                    wr_en   = 1'b1;
                    count_d = count_q + CNT_W'(1);
                  end else begin
                    ovf_d = 1'b1;
                  end
                end
              end
            end
            lioc_pkg::OP_QUERY: begin
              off_d      = (query_ext < len_ext) ? query_ext[OFF_W-1:0] : len_q;
              lo_d       = '0;
              hi_d       = count_q;
              best_d     = '0;
              mid_n      = count_q >> 1;
              mid_d      = mid_n;
              mid_zero_d = (mid_n == '0);
              rd_en      = 1'b1;
              rd_addr    = mid_n[IDX_W-1:0];
              state_d    = ST_SRCH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRCH: begin
        if (probe_start <= off_q) begin
          lo_n   = mid_q + CNT_W'(1);
          best_d = probe_start;
        end else begin
          hi_n = mid_q;
        end
        mid_n      = lo_n + ((hi_n - lo_n) >> 1);
        lo_d       = lo_n;
        hi_d       = hi_n;
        mid_d      = mid_n;
        mid_zero_d = (mid_n == '0);
        if (lo_n < hi_n) begin
          rd_en   = 1'b1;
          rd_addr = mid_n[IDX_W-1:0];
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {{PAD_W{1'b0}}, ovf_q, colx[lioc_pkg::COL_W-1:0],
                       lnx[lioc_pkg::LINE_W-1:0]};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= CNT_W'(1);
      len_q     <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q   <= m_data_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    mid_zero_q <= mid_zero_d;
    off_q      <= off_d;
    best_q     <= best_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  `LIOC_ASSERT_SAME(a_srch_open, clk_i, rst_ni, state_q == ST_SRCH, lo_q < hi_q, "search window empty")
  `LIOC_ASSERT_SAME(a_srch_hi, clk_i, rst_ni, state_q == ST_SRCH, hi_q <= count_q, "search past table fill")
  `LIOC_ASSERT_SAME(a_count_rng, clk_i, rst_ni, 1'b1, count_q >= CNT_W'(1) && count_q <= CNT_W'(MAX_LINES), "line count out of range")
  `LIOC_ASSERT_SAME(a_out_src, clk_i, rst_ni, $rose(m_valid_q), $past(state_q) == ST_OUT, "result without search end")
  `LIOC_ASSERT_NEXT(a_query_srch, clk_i, rst_ni, in_fire && opcode == lioc_pkg::OP_QUERY, state_q == ST_SRCH, "query did not start search")

endmodule

// File: tb/sv/tb_line_index_offset_to_line_col.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line index locator testbench
// Streams clear, append, query and unused-opcode requests into the block under varying
// backpressure on both ports. A scoreboard keeps its own line-start table and
// text length, predicts each query answer, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_line_index_offset_to_line_col;

  localparam int MAX_LINES   = 4096;
  localparam int OFFSET_BITS = 16;
  localparam int TEXT_CAP    = (1 << OFFSET_BITS) - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 440;

  typedef logic [lioc_pkg::OPCODE_W-1:0]    op_t;
  typedef logic [lioc_pkg::TEXT_BYTE_W-1:0] byte_t;
  typedef logic [lioc_pkg::QUERY_W-1:0]     offset_t;
  typedef logic [lioc_pkg::LINE_W-1:0]      line_t;
  typedef logic [lioc_pkg::COL_W-1:0]       col_t;

  localparam op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    line_t line_no;
    col_t  col_no;
    logic  ovf;
  } location_t;

  class line_locator_model;
    offset_t     line_starts [MAX_LINES];
    int unsigned line_cnt;
    int unsigned text_len;
    bit          dropped;
    location_t   pending_locations [$];
    int unsigned errors;

    function void clear_text();
      line_starts[0] = '0;
      line_cnt = 1;
      text_len = 0;
      dropped = 1'b0;
    endfunction

    function void note_request(op_t op, byte_t b, offset_t q);
      int unsigned off;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      location_t   loc;
      case (op)
        lioc_pkg::OP_CLEAR: clear_text();
        lioc_pkg::OP_APPEND: begin
          if (text_len >= TEXT_CAP) begin
            dropped = 1'b1;
          end else begin
            text_len++;
            if (b == lioc_pkg::NEWLINE_BYTE) begin
              if (line_cnt < MAX_LINES) begin
                line_starts[line_cnt] = offset_t'(text_len);
                line_cnt++;
              end else begin
                dropped = 1'b1;
              end
            end
          end
        end
        lioc_pkg::OP_QUERY: begin
          off = (q < text_len) ? q : text_len;
          lo = 0;
          hi = line_cnt;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (line_starts[mid] <= off) lo = mid + 1;
            else hi = mid;
          end
          loc.line_no = line_t'(lo);
          loc.col_no  = col_t'(off - line_starts[lo-1] + 1);
          loc.ovf     = dropped;
          pending_locations.insert(pending_locations.size(), loc);
        end
        default: ;
      endcase
    endfunction

    function void check_location(logic [lioc_pkg::M_TDATA_W-1:0] tdata);
      location_t want;
      location_t got;
      got.line_no = tdata[lioc_pkg::LINE_W-1:0];
      got.col_no  = tdata[lioc_pkg::LINE_W+lioc_pkg::COL_W-1:lioc_pkg::LINE_W];
      got.ovf     = tdata[lioc_pkg::LINE_W+lioc_pkg::COL_W];
      if (pending_locations.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual line %0d col %0d ovf %0d",
                 $time, got.line_no, got.col_no, got.ovf);
        errors++;
        return;
      end
      want = pending_locations.pop_front();
      if (got.line_no !== want.line_no) begin
        $display("%0t: line_number expected %0d actual %0d", $time, want.line_no,
                 got.line_no);
        errors++;
      end
      if (got.col_no !== want.col_no) begin
        $display("%0t: column_number expected %0d actual %0d", $time, want.col_no,
                 got.col_no);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $display("%0t: overflow_flag expected %0d actual %0d", $time, want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [lioc_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  op_t                            s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [lioc_pkg::M_TDATA_W-1:0] m_axis_tdata;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  line_locator_model locator;

  line_index_offset_to_line_col #(
    .MAX_LINES  (MAX_LINES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) locator.check_location(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input op_t op, input byte_t b, input offset_t q);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {q, b};
    do @(posedge clk_i); while (!s_axis_tready);
    locator.note_request(op, b, q);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (locator.pending_locations.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic offset_t pick_offset();
    int unsigned sel;
    int unsigned idx;
    int unsigned off;
    sel = $urandom_range(9);
    if (sel <= 4) begin
      off = $urandom_range(0, locator.text_len + 3);
    end else if (sel <= 6) begin
      idx = $urandom_range(0, locator.line_cnt - 1);
      off = locator.line_starts[idx];
      if (off > 0 && $urandom_range(1)) off--;
    end else if (sel == 7) begin
      off = locator.text_len;
    end else begin
      off = $urandom_range(0, 65535);
    end
    return off[lioc_pkg::QUERY_W-1:0];
  endfunction

  task automatic run_directed();
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'h0000);
    send_request(lioc_pkg::OP_QUERY, 8'hFF, 16'hFFFF);
    send_request(lioc_pkg::OP_APPEND, 8'h61, 16'hFFFF);
    send_request(lioc_pkg::OP_APPEND, lioc_pkg::NEWLINE_BYTE, 16'h0000);
    send_request(lioc_pkg::OP_APPEND, 8'hFF, 16'h5A5A);
    send_request(lioc_pkg::OP_APPEND, 8'h00, 16'hA5A5);
    send_request(lioc_pkg::OP_APPEND, 8'h0B, 16'h0000);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'd0);
    send_request(lioc_pkg::OP_QUERY, 8'hFF, 16'd1);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'd2);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'd3);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'hFFFF);
    send_request(OP_UNUSED, 8'hFF, 16'hFFFF);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'd5);
    send_request(lioc_pkg::OP_CLEAR, 8'hFF, 16'hFFFF);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'd5);
    send_request(lioc_pkg::OP_APPEND, lioc_pkg::NEWLINE_BYTE, 16'h0000);
    send_request(lioc_pkg::OP_APPEND, lioc_pkg::NEWLINE_BYTE, 16'h0000);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'd1);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'd2);
    send_request(lioc_pkg::OP_QUERY, 8'h00, 16'd0);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned n;
    int unsigned sel;
    byte_t b;
    sent = 0;
    while (sent < target) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        if ($urandom_range(99) < 30) begin
          send_request(lioc_pkg::OP_CLEAR, byte_t'($urandom_range(0, 255)),
                       offset_t'($urandom_range(0, 65535)));
          sent++;
        end
        n = $urandom_range(0, 30);
        repeat (n) begin
          b = ($urandom_range(3) == 0) ? lioc_pkg::NEWLINE_BYTE
                                       : byte_t'($urandom_range(0, 255));
          send_request(lioc_pkg::OP_APPEND, b, offset_t'($urandom_range(0, 65535)));
          sent++;
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_request(lioc_pkg::OP_QUERY, byte_t'($urandom_range(0, 255)), pick_offset());
          sent++;
        end
      end else if (sel < 92) begin
        send_request(OP_UNUSED, byte_t'($urandom_range(0, 255)),
                     offset_t'($urandom_range(0, 65535)));
      end else begin
        send_request(op_t'($urandom_range(0, 2)), byte_t'($urandom_range(0, 255)),
                     offset_t'($urandom_range(0, 65535)));
        sent++;
      end
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  initial begin
    locator = new();
    locator.clear_text();
    locator.errors = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 65 : 0;
      rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 38 : 0;
      if (phase == 0) run_directed();
      run_random(ITEMS_PER_PHASE);
      drain_results();
    end
    repeat (30) @(posedge clk_i);
    if (locator.errors == 0 && locator.pending_locations.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
